FILE: rtl/assert_macros.svh
// Assertion helpers for the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/ncdf_pkg.sv
package ncdf_pkg;
	localparam logic [4:0] PH_MAGIC = 5'd0;
	localparam logic [4:0] PH_NUMRECS = 5'd1;
	localparam logic [4:0] PH_DIM_TAG = 5'd2;
	localparam logic [4:0] PH_DIM_COUNT = 5'd3;
	localparam logic [4:0] PH_DIM_NONE = 5'd4;
	localparam logic [4:0] PH_NAME_LEN = 5'd5;
	localparam logic [4:0] PH_NAME_BODY = 5'd6;
	localparam logic [4:0] PH_DIM_SIZE = 5'd7;
	localparam logic [4:0] PH_ATT_TAG = 5'd8;
	localparam logic [4:0] PH_ATT_COUNT = 5'd9;
	localparam logic [4:0] PH_ATT_NONE = 5'd10;
	localparam logic [4:0] PH_ATT_TYPE = 5'd11;
	localparam logic [4:0] PH_ATT_NELEMS = 5'd12;
	localparam logic [4:0] PH_ATT_ELEM = 5'd13;
	localparam logic [4:0] PH_ATT_PAD = 5'd14;
	localparam logic [4:0] PH_VAR_TAG = 5'd15;
	localparam logic [4:0] PH_VAR_COUNT = 5'd16;
	localparam logic [4:0] PH_VAR_NONE = 5'd17;
	localparam logic [4:0] PH_VAR_NDIMS = 5'd18;
	localparam logic [4:0] PH_VAR_DIMID = 5'd19;
	localparam logic [4:0] PH_VAR_TYPE = 5'd20;
	localparam logic [4:0] PH_VAR_SIZE = 5'd21;
	localparam logic [4:0] PH_VAR_BEGIN = 5'd22;
	localparam logic [4:0] PH_DONE = 5'd23;
	localparam logic [4:0] PH_HALT = 5'd24;

	localparam logic [3:0] K_VERSION = 4'd0;
	localparam logic [3:0] K_NUMRECS = 4'd1;
	localparam logic [3:0] K_DIM_COUNT = 4'd2;
	localparam logic [3:0] K_NAME = 4'd3;
	localparam logic [3:0] K_DIM_SIZE = 4'd4;
	localparam logic [3:0] K_ATT_COUNT = 4'd5;
	localparam logic [3:0] K_ATT_TYPE = 4'd6;
	localparam logic [3:0] K_ATT_ELEM = 4'd7;
	localparam logic [3:0] K_VAR_COUNT = 4'd8;
	localparam logic [3:0] K_VAR_DIMID = 4'd9;
	localparam logic [3:0] K_VAR_TYPE = 4'd10;
	localparam logic [3:0] K_VAR_SIZE = 4'd11;
	localparam logic [3:0] K_VAR_BEGIN = 4'd12;
	localparam logic [3:0] K_DONE = 4'd13;
	localparam logic [3:0] K_ERROR = 4'd14;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_MAGIC = 3'd1;
	localparam logic [2:0] E_VERSION = 3'd2;
	localparam logic [2:0] E_DIM_TAG = 3'd3;
	localparam logic [2:0] E_ATT_TAG = 3'd4;
	localparam logic [2:0] E_VAR_TAG = 3'd5;
	localparam logic [2:0] E_TYPE = 3'd6;

	localparam logic [1:0] SC_DIM = 2'd0;
	localparam logic [1:0] SC_GATT = 2'd1;
	localparam logic [1:0] SC_VAR = 2'd2;
	localparam logic [1:0] SC_VATT = 2'd3;

	localparam logic [7:0] MAGIC_C = 8'h43;
	localparam logic [7:0] MAGIC_D = 8'h44;
	localparam logic [7:0] MAGIC_F = 8'h46;
	localparam logic [31:0] TAG_DIM = 32'h0A;
	localparam logic [31:0] TAG_ATT = 32'h0C;
	localparam logic [31:0] TAG_VAR = 32'h0B;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [1:0]  scope;
		logic [2:0]  error_code;
	} token_t;

	// bytes per element for an attribute type
	function automatic logic [3:0] elem_size(input logic [2:0] t);
		case (t)
			3'd1, 3'd2: elem_size = 4'd1;
			3'd3: elem_size = 4'd2;
			3'd6: elem_size = 4'd8;
			default: elem_size = 4'd4;
		endcase
	endfunction
endpackage

FILE: rtl/netcdf_classic_header_parser_top.sv
// Header parser: takes a NetCDF classic or 64-bit-offset header one byte
// per beat and emits at most one token per byte.
// Input channel: data_byte, first with in_valid / in_stall. A beat with
// first high restarts the parse at the magic bytes.
// Output channel: kind, value, scope, error_code with out_valid /
// out_stall. Bytes that complete no field give no token.
// A token reaches the output through the input register and then the
// result buffer. Throughput: one byte per cycle while in_stall is low;
// the parse state updates once per byte in a single pass of logic between
// the input register and the result register.
// Reset clears the parse state as if a header starts with the next byte and
// empties both registers. When the receiver stalls, the result buffer holds
// up to two tokens; in_stall rises once its spare slot is taken and the
// input holds still until the receiver takes a token.
`include "assert_macros.svh"
module netcdf_classic_header_parser_top
	import ncdf_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [63:0] value,
	output logic [1:0]  scope,
	output logic [2:0]  error_code
);
	localparam int CB = COUNT_BITS;

	// input register
	logic       v_s1;
	logic [7:0] b_s1;
	logic       f_s1;
	logic       buf_stall;
	logic       s1_go;

	assign s1_go = !v_s1 || !buf_stall;
	assign in_stall = !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (s1_go) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (s1_go && in_valid) begin
			b_s1 <= data_byte;
			f_s1 <= first;
		end
	end

	// parse state
	logic [4:0]    phase_q;
	logic [2:0]    bif_q;
	logic [63:0]   shift_q;
	logic          wide_q;
	logic [CB-1:0] dims_q, attrs_q, vars_q, vdims_q, elems_q;
	logic [1:0]    pad_q;
	logic [2:0]    etype_q;
	logic          invar_q;
	logic          stop_q;
	logic [1:0]    nscope_q;

	logic [4:0]    phase_d;
	logic [2:0]    bif_d;
	logic [63:0]   shift_d;
	logic          wide_d;
	logic [CB-1:0] dims_d, attrs_d, vars_d, vdims_d, elems_d;
	logic [1:0]    pad_d;
	logic [2:0]    etype_d;
	logic          invar_d;
	logic          stop_d;
	logic [1:0]    nscope_d;
	logic          emit;
	token_t        tok;

	// step the parse for one byte
	always_comb begin
		logic [4:0]    ph;
		logic [2:0]    bif;
		logic [63:0]   sh;
		logic [63:0]   v;
		logic [3:0]    len;
		logic          done;
		logic [CB-1:0] n;
		logic [1:0]    asc;
		logic [3:0]    esz;
		phase_d = phase_q; bif_d = bif_q; shift_d = shift_q; wide_d = wide_q;
		dims_d = dims_q; attrs_d = attrs_q; vars_d = vars_q; vdims_d = vdims_q;
		elems_d = elems_q; pad_d = pad_q; etype_d = etype_q; invar_d = invar_q;
		stop_d = stop_q; nscope_d = nscope_q;
		if (f_s1) begin
			phase_d = PH_MAGIC; bif_d = '0; shift_d = '0; wide_d = 1'b0;
			dims_d = '0; attrs_d = '0; vars_d = '0; vdims_d = '0; elems_d = '0;
			pad_d = '0; etype_d = '0; invar_d = 1'b0; stop_d = 1'b0; nscope_d = '0;
		end
		ph = phase_d;
		bif = bif_d;
		sh = {shift_d[55:0], b_s1};
		emit = 1'b0;
		tok = '{kind: K_DONE, value: '0, scope: SC_DIM, error_code: E_NONE};
		asc = invar_d ? SC_VATT : SC_GATT;
		esz = elem_size(etype_d);
		len = 4'd4;
		if (ph == PH_ATT_ELEM) len = esz;
		if (ph == PH_VAR_BEGIN && wide_d) len = 4'd8;
		done = ({1'b0, bif} + 4'd1) >= len;
		v = sh;
		n = v[CB-1:0];
		if (!(stop_d && !f_s1)) begin
			// generic field accumulate for multi-byte phases
			if (ph != PH_MAGIC && ph != PH_NAME_BODY && ph != PH_ATT_PAD &&
			    ph != PH_DONE && ph != PH_HALT) begin
				if (done) begin
					shift_d = '0;
					bif_d = '0;
				end else begin
					shift_d = sh;
					bif_d = bif + 3'd1;
				end
			end
			case (ph)
				PH_MAGIC: begin
					if (bif < 3'd3) begin
						if (b_s1 != (bif == 3'd0 ? MAGIC_C : bif == 3'd1 ? MAGIC_D : MAGIC_F))
						begin
							emit = 1'b1;
							tok = '{K_ERROR, {56'd0, b_s1}, SC_DIM, E_MAGIC};
							phase_d = PH_HALT; stop_d = 1'b1;
						end else bif_d = bif + 3'd1;
					end else begin
						bif_d = '0;
						emit = 1'b1;
						if (b_s1 != 8'd1 && b_s1 != 8'd2) begin
							tok = '{K_ERROR, {56'd0, b_s1}, SC_DIM, E_VERSION};
							phase_d = PH_HALT; stop_d = 1'b1;
						end else begin
							wide_d = (b_s1 == 8'd2);
							phase_d = PH_NUMRECS;
							tok = '{K_VERSION, {56'd0, b_s1}, SC_DIM, E_NONE};
						end
					end
				end
				PH_NUMRECS: if (done) begin
					phase_d = PH_DIM_TAG; emit = 1'b1;
					tok = '{K_NUMRECS, v, SC_DIM, E_NONE};
				end
				PH_DIM_TAG, PH_ATT_TAG, PH_VAR_TAG: if (done) begin
					if (v == {32'd0, (ph == PH_DIM_TAG ? TAG_DIM :
					    ph == PH_ATT_TAG ? TAG_ATT : TAG_VAR)})
						phase_d = ph + 5'd1;
					else if (v == 64'd0) phase_d = ph + 5'd2;
					else begin
						emit = 1'b1;
						tok = '{K_ERROR, v, SC_DIM, (ph == PH_DIM_TAG ? E_DIM_TAG :
						    ph == PH_ATT_TAG ? E_ATT_TAG : E_VAR_TAG)};
						phase_d = PH_HALT; stop_d = 1'b1;
					end
				end
				PH_DIM_COUNT, PH_DIM_NONE: if (done) begin
					if (ph == PH_DIM_NONE) n = '0;
					dims_d = n; emit = 1'b1;
					tok = '{K_DIM_COUNT, 64'(n), SC_DIM, E_NONE};
					if (n == '0) begin invar_d = 1'b0; phase_d = PH_ATT_TAG; end
					else begin nscope_d = SC_DIM; phase_d = PH_NAME_LEN; end
				end
				PH_ATT_COUNT, PH_ATT_NONE: if (done) begin
					if (ph == PH_ATT_NONE) n = '0;
					attrs_d = n; emit = 1'b1;
					tok = '{K_ATT_COUNT, 64'(n), asc, E_NONE};
					if (n == '0) phase_d = invar_d ? PH_VAR_TYPE : PH_VAR_TAG;
					else begin nscope_d = asc; phase_d = PH_NAME_LEN; end
				end
				PH_VAR_COUNT, PH_VAR_NONE: if (done) begin
					if (ph == PH_VAR_NONE) n = '0;
					vars_d = n; emit = 1'b1;
					tok = '{K_VAR_COUNT, 64'(n), SC_VAR, E_NONE};
					if (n == '0) phase_d = PH_DONE;
					else begin nscope_d = SC_VAR; phase_d = PH_NAME_LEN; end
				end
				PH_NAME_LEN: if (done) begin
					elems_d = n;
					pad_d = 2'(-n[1:0]);
					if (n == '0) begin
						phase_d = nscope_d == SC_DIM ? PH_DIM_SIZE :
						    nscope_d == SC_VAR ? PH_VAR_NDIMS : PH_ATT_TYPE;
					end else phase_d = PH_NAME_BODY;
				end
				PH_NAME_BODY: begin
					if (elems_d != '0) begin
						elems_d = elems_d - 1'b1;
						emit = 1'b1;
						tok = '{K_NAME, {56'd0, b_s1}, nscope_d, E_NONE};
						if (elems_d == '0 && pad_d == 2'd0)
							phase_d = nscope_d == SC_DIM ? PH_DIM_SIZE :
							    nscope_d == SC_VAR ? PH_VAR_NDIMS : PH_ATT_TYPE;
					end else begin
						pad_d = pad_d - 2'd1;
						if (pad_d == 2'd0)
							phase_d = nscope_d == SC_DIM ? PH_DIM_SIZE :
							    nscope_d == SC_VAR ? PH_VAR_NDIMS : PH_ATT_TYPE;
					end
				end
				PH_DIM_SIZE: if (done) begin
					dims_d = dims_d - 1'b1; emit = 1'b1;
					tok = '{K_DIM_SIZE, v, SC_DIM, E_NONE};
					if (dims_d == '0) begin invar_d = 1'b0; phase_d = PH_ATT_TAG; end
					else begin nscope_d = SC_DIM; phase_d = PH_NAME_LEN; end
				end
				PH_ATT_TYPE, PH_VAR_TYPE: if (done) begin
					emit = 1'b1;
					if (v < 64'd1 || v > 64'd6) begin
						tok = '{K_ERROR, v, SC_DIM, E_TYPE};
						phase_d = PH_HALT; stop_d = 1'b1;
					end else if (ph == PH_ATT_TYPE) begin
						etype_d = v[2:0]; phase_d = PH_ATT_NELEMS;
						tok = '{K_ATT_TYPE, v, asc, E_NONE};
					end else begin
						phase_d = PH_VAR_SIZE;
						tok = '{K_VAR_TYPE, v, SC_VAR, E_NONE};
					end
				end
				PH_ATT_NELEMS: if (done) begin
					elems_d = n;
					if (esz == 4'd1) pad_d = 2'(-n[1:0]);
					else if (esz == 4'd2) pad_d = n[0] ? 2'd2 : 2'd0;
					else pad_d = 2'd0;
					if (n == '0) begin
						attrs_d = attrs_d - 1'b1;
						if (attrs_d == '0) phase_d = invar_d ? PH_VAR_TYPE : PH_VAR_TAG;
						else begin nscope_d = asc; phase_d = PH_NAME_LEN; end
					end else phase_d = PH_ATT_ELEM;
				end
				PH_ATT_ELEM: if (done) begin
					elems_d = elems_d - 1'b1; emit = 1'b1;
					tok = '{K_ATT_ELEM, v, asc, E_NONE};
					if (elems_d == '0) begin
						if (pad_d != 2'd0) phase_d = PH_ATT_PAD;
						else begin
							attrs_d = attrs_d - 1'b1;
							if (attrs_d == '0) phase_d = invar_d ? PH_VAR_TYPE : PH_VAR_TAG;
							else begin nscope_d = asc; phase_d = PH_NAME_LEN; end
						end
					end
				end
				PH_ATT_PAD: begin
					pad_d = pad_d - 2'd1;
					if (pad_d == 2'd0) begin
						attrs_d = attrs_d - 1'b1;
						if (attrs_d == '0) phase_d = invar_d ? PH_VAR_TYPE : PH_VAR_TAG;
						else begin nscope_d = asc; phase_d = PH_NAME_LEN; end
					end
				end
				PH_VAR_NDIMS: if (done) begin
					vdims_d = n; invar_d = 1'b1;
					phase_d = (n == '0) ? PH_ATT_TAG : PH_VAR_DIMID;
				end
				PH_VAR_DIMID: if (done) begin
					vdims_d = vdims_d - 1'b1; emit = 1'b1;
					tok = '{K_VAR_DIMID, v, SC_VAR, E_NONE};
					if (vdims_d == '0) phase_d = PH_ATT_TAG;
				end
				PH_VAR_SIZE: if (done) begin
					phase_d = PH_VAR_BEGIN; emit = 1'b1;
					tok = '{K_VAR_SIZE, v, SC_VAR, E_NONE};
				end
				PH_VAR_BEGIN: if (done) begin
					vars_d = vars_d - 1'b1; invar_d = 1'b0; emit = 1'b1;
					tok = '{K_VAR_BEGIN, v, SC_VAR, E_NONE};
					if (vars_d == '0) phase_d = PH_DONE;
					else begin nscope_d = SC_VAR; phase_d = PH_NAME_LEN; end
				end
				PH_DONE: begin
					phase_d = PH_HALT; stop_d = 1'b1; emit = 1'b1;
					tok = '{K_DONE, 64'd0, SC_DIM, E_NONE};
				end
				default: begin
					phase_d = PH_HALT; stop_d = 1'b1;
				end
			endcase
		end
	end

	logic s1_fire;
	assign s1_fire = v_s1 && !buf_stall;

	// commit the state once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; bif_q <= '0; shift_q <= '0; wide_q <= 1'b0;
			dims_q <= '0; attrs_q <= '0; vars_q <= '0; vdims_q <= '0; elems_q <= '0;
			pad_q <= '0; etype_q <= '0; invar_q <= 1'b0; stop_q <= 1'b0;
			nscope_q <= '0;
		end else if (s1_fire) begin
			phase_q <= phase_d; bif_q <= bif_d; shift_q <= shift_d; wide_q <= wide_d;
			dims_q <= dims_d; attrs_q <= attrs_d; vars_q <= vars_d; vdims_q <= vdims_d;
			elems_q <= elems_d; pad_q <= pad_d; etype_q <= etype_d; invar_q <= invar_d;
			stop_q <= stop_d; nscope_q <= nscope_d;
		end
	end

	token_t out_tok;
	ncdf_out_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_fire && emit),
		.in_tok   (tok),
		.in_stall (buf_stall),
		.out_valid(out_valid),
		.out_tok  (out_tok),
		.out_stall(out_stall)
	);

	assign kind = out_tok.kind;
	assign value = out_tok.value;
	assign scope = out_tok.scope;
	assign error_code = out_tok.error_code;

	`CHK_IMPL(a_err_code, clk, arst_n, out_valid && kind != K_ERROR, error_code == E_NONE)
	`CHK_IMPL(a_err_nz, clk, arst_n, out_valid && kind == K_ERROR, error_code != E_NONE)
	`CHK_NEXT(a_stop_halt, clk, arst_n, s1_fire && stop_d, phase_q == PH_HALT)
	`CHK_IMPL(a_bif_rng, clk, arst_n, phase_q == PH_MAGIC, bif_q <= 3'd3)
endmodule

FILE: rtl/ncdf_out_buf.sv
// Two-entry skid buffer for result tokens.
module ncdf_out_buf
	import ncdf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  token_t in_tok,
	output logic   in_stall,
	output logic   out_valid,
	output token_t out_tok,
	input  logic   out_stall
);
	logic   full_q, skid_q;
	token_t main_q, skid_tok_q;

	assign in_stall = skid_q;
	assign out_valid = full_q;
	assign out_tok = main_q;

	// advance main register, park a beat in the skid slot on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			skid_q <= 1'b0;
		end else begin
			if (!full_q || !out_stall) begin
				if (skid_q) begin
					full_q <= 1'b1;
					skid_q <= in_valid;
				end else begin
					full_q <= in_valid;
				end
			end else if (in_valid && !skid_q) begin
				skid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!full_q || !out_stall) begin
			if (skid_q) begin
				main_q <= skid_tok_q;
				if (in_valid) skid_tok_q <= in_tok;
			end else begin
				main_q <= in_tok;
			end
		end else if (in_valid && !skid_q) begin
			skid_tok_q <= in_tok;
		end
	end
endmodule
